FILE: rtl/tkt_pkg.sv
package tkt_pkg;

  localparam int COUNT_W  = 7;
  localparam int ID_W     = 64;
  localparam int STATUS_W = 8;
  localparam int NUMBER_W = 32;
  localparam int VALUE_W  = 64;
  localparam int CODE_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  typedef enum logic [CODE_W-1:0] {
    RC_UPDATED   = 2'd0,
    RC_INSERTED  = 2'd1,
    RC_FULL      = 2'd2,
    RC_NOT_FOUND = 2'd3
  } code_t;

  // Request fields held steady while a request is in the table.
  typedef struct packed {
    logic [ID_W-1:0]     client_id;
    logic [ID_W-1:0]     server_id;
    logic [STATUS_W-1:0] key_status;
    logic [NUMBER_W-1:0] key_number;
    logic [VALUE_W-1:0]  key_value;
  } req_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic                free;
    logic [STATUS_W-1:0] status;
    logic [NUMBER_W-1:0] number;
    logic [VALUE_W-1:0]  value;
  } token_t;

  // Commit command broadcast to all cells for one cycle.
  typedef struct packed {
    logic wr_hit;
    logic wr_free;
  } cmd_t;

endpackage

FILE: rtl/tkt_cell.sv
module tkt_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tkt_pkg::COUNT_W-1:0]     count,
  input  tkt_pkg::req_t                   req,
  input  tkt_pkg::cmd_t                   cmd,
  input  tkt_pkg::token_t                 tok_in,
  output tkt_pkg::token_t                 tok_out
);

  localparam logic [31:0] MY_INDEX = 32'(CELL_INDEX);

  logic                          valid;
  logic                          hit_mark;
  logic                          free_mark;
  logic [tkt_pkg::ID_W-1:0]      client_q;
  logic [tkt_pkg::ID_W-1:0]      server_q;
  logic [tkt_pkg::STATUS_W-1:0]  status_q;
  logic [tkt_pkg::NUMBER_W-1:0]  number_q;
  logic [tkt_pkg::VALUE_W-1:0]   value_q;

  logic                          en;
  logic [tkt_pkg::ID_W-1:0]      client_r;
  logic [tkt_pkg::ID_W-1:0]      server_r;
  logic [tkt_pkg::STATUS_W-1:0]  status_r;
  logic [tkt_pkg::NUMBER_W-1:0]  number_r;
  logic [tkt_pkg::VALUE_W-1:0]   value_r;
  logic                          match;
  logic                          empty;
  logic                          first_hit;
  logic                          first_free;
  logic                          write_now;

  // An entry never written reads as all zero.
  assign client_r = valid ? client_q : '0;
  assign server_r = valid ? server_q : '0;
  assign status_r = valid ? status_q : '0;
  assign number_r = valid ? number_q : '0;
  assign value_r  = valid ? value_q  : '0;

  assign en    = 32'(count) > MY_INDEX;
  assign match = en && (client_r == req.client_id) && (server_r == req.server_id);
  assign empty = en && (client_r == '0) && (server_r == '0) && (status_r == '0) &&
                 (number_r == '0) && (value_r == '0);

  assign first_hit  = match && !tok_in.hit;
  assign first_free = empty && !tok_in.free;
  assign write_now  = (cmd.wr_hit && hit_mark) || (cmd.wr_free && free_mark);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      hit_mark      <= 1'b0;
      free_mark     <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid) begin
        hit_mark  <= first_hit;
        free_mark <= first_free;
      end
      if (write_now) begin
        valid <= 1'b1;
      end
    end
    tok_out.hit  <= tok_in.hit || match;
    tok_out.free <= tok_in.free || empty;
    if (first_hit) begin
      tok_out.status <= status_r;
      tok_out.number <= number_r;
      tok_out.value  <= value_r;
    end else begin
      tok_out.status <= tok_in.status;
      tok_out.number <= tok_in.number;
      tok_out.value  <= tok_in.value;
    end
    if (write_now) begin
      client_q <= req.client_id;
      server_q <= req.server_id;
      status_q <= req.key_status;
      number_q <= req.key_number;
      value_q  <= req.key_value;
    end
  end

endmodule

FILE: rtl/two_key_table_upsert_lookup.sv
// Key table with two-identifier lookup, built as a chain of TABLE_DEPTH cells.
// Each cell holds one record (client id, server id, status, number, value).
// A request is accepted on a rising edge with start high and busy low; mode 0
// writes or updates a record, mode 1 reads one. The request fields are held
// in a register and seen by every cell, while a search token walks the chain
// one cell per cycle and collects the first match, the first empty entry and
// the matched record's data. Cells at or beyond entries_in_use are skipped.
// The result is marked by result_valid for one cycle, and the same cycle
// commits a write into the chosen cell. busy falls at the edge that takes
// the result, so it stays high during the walk along the cell chain and
// no new request is accepted before the previous result has been shown.
// entries_in_use is written through cfg_write and cfg_data; the user must
// do so only while idle, which the block itself does not enforce.
// The receiver cannot stall; every result must be taken when it is shown.
// Reset clears every record to zero, sets entries_in_use to 64 and leaves
// the block idle, ready for a request in the next cycle.
module two_key_table_upsert_lookup #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tkt_pkg::COUNT_W-1:0]       cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode,
  input  logic [tkt_pkg::ID_W-1:0]          client_id,
  input  logic [tkt_pkg::ID_W-1:0]          server_id,
  input  logic [tkt_pkg::STATUS_W-1:0]      key_status,
  input  logic [tkt_pkg::NUMBER_W-1:0]      key_number,
  input  logic [tkt_pkg::VALUE_W-1:0]       key_value,
  output logic                              result_valid,
  output logic [tkt_pkg::CODE_W-1:0]        result_code,
  output logic [tkt_pkg::STATUS_W-1:0]      found_status,
  output logic [tkt_pkg::NUMBER_W-1:0]      found_number,
  output logic [tkt_pkg::VALUE_W-1:0]       found_value
);

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    DONE
  } state_t;

  state_t                          state;
  logic [tkt_pkg::COUNT_W-1:0]     entries_in_use;
  tkt_pkg::req_t                   req;
  logic                            req_read;
  tkt_pkg::token_t                 launch;
  tkt_pkg::cmd_t                   cmd;
  tkt_pkg::token_t                 tok [TABLE_DEPTH+1];
  tkt_pkg::token_t                 tail;
  logic                            accept;
  logic                            walk_done;

  assign accept    = start && (state == IDLE);
  assign busy      = (state != IDLE);
  assign tok[0]    = launch;
  assign tail      = tok[TABLE_DEPTH];
  assign walk_done = (state == SEARCH) && tail.valid;

  // The chain itself: each cell compares the held request against its own
  // record when the token passes, and hands the token on in the next cycle.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tkt_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .count  (entries_in_use),
      .req    (req),
      .cmd    (cmd),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= tkt_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      entries_in_use <= cfg_data;
    end
  end

  // Request register, loaded when a request is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_read       <= mode;
      req.client_id  <= client_id;
      req.server_id  <= server_id;
      req.key_status <= key_status;
      req.key_number <= key_number;
      req.key_value  <= key_value;
    end
  end

  // Sequencer: launch the token, wait for it at the end of the chain, then
  // show the result and commit a write in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      launch       <= '0;
      cmd          <= '0;
      result_valid <= 1'b0;
      result_code  <= tkt_pkg::RC_UPDATED;
      found_status <= '0;
      found_number <= '0;
      found_value  <= '0;
    end else begin
      launch.valid <= accept;
      result_valid <= walk_done;
      // An update wins over an insert; with neither the table is left alone.
      cmd.wr_hit   <= walk_done && !req_read && tail.hit;
      cmd.wr_free  <= walk_done && !req_read && !tail.hit && tail.free;
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= SEARCH;
          end
        end
        SEARCH: begin
          if (tail.valid) begin
            if (req_read) begin
              if (tail.hit) begin
                result_code  <= tkt_pkg::RC_UPDATED;
                found_status <= tail.status;
                found_number <= tail.number;
                found_value  <= tail.value;
              end else begin
                result_code  <= tkt_pkg::RC_NOT_FOUND;
                found_status <= '0;
                found_number <= '0;
                found_value  <= '0;
              end
            end else begin
              found_status <= '0;
              found_number <= '0;
              found_value  <= '0;
              priority if (tail.hit) begin
                result_code <= tkt_pkg::RC_UPDATED;
              end else if (tail.free) begin
                result_code <= tkt_pkg::RC_INSERTED;
              end else begin
                result_code <= tkt_pkg::RC_FULL;
              end
            end
            state <= DONE;
          end
        end
        DONE: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: verif/tb_two_key_table_upsert_lookup.sv
module tb_two_key_table_upsert_lookup;

  localparam int DEPTH      = 64;
  localparam int CYCLE_CAP  = 500000;
  localparam int DRAIN_WAIT = DEPTH + 8;
  localparam int POOL_SIZE  = 128;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // One request as the block sees it on its input ports.
  typedef struct packed {
    logic                         rd;
    logic [tkt_pkg::ID_W-1:0]     client;
    logic [tkt_pkg::ID_W-1:0]     server;
    logic [tkt_pkg::STATUS_W-1:0] status;
    logic [tkt_pkg::NUMBER_W-1:0] number;
    logic [tkt_pkg::VALUE_W-1:0]  value;
  } request_t;

  // One answer as the block shows it on its result ports.
  typedef struct packed {
    tkt_pkg::code_t               code;
    logic [tkt_pkg::STATUS_W-1:0] status;
    logic [tkt_pkg::NUMBER_W-1:0] number;
    logic [tkt_pkg::VALUE_W-1:0]  value;
  } outcome_t;

  localparam outcome_t NO_CHECK = '0;

  typedef enum logic {ROW_REQUEST, ROW_SPAN} row_kind_t;

  // A row of the directed table: either a request or a write of the entry count.
  // When "typed" is set, the answer in "want" was written by hand and replaces
  // the predicted one; the predictor still runs so that its table stays in step.
  typedef struct {
    row_kind_t                   kind;
    logic [tkt_pkg::COUNT_W-1:0] span;
    request_t                    req;
    bit                          typed;
    outcome_t                    want;
  } row_t;

  // A phase of the random part: entry count, sender idle percentage, number of
  // requests, how many identifier pairs of the pool are in play, write share.
  typedef struct {
    int span;
    int idle;
    int items;
    int pool;
    int wr;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [tkt_pkg::COUNT_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic mode = MODE_WRITE;
  logic [tkt_pkg::ID_W-1:0] client_id = '0;
  logic [tkt_pkg::ID_W-1:0] server_id = '0;
  logic [tkt_pkg::STATUS_W-1:0] key_status = '0;
  logic [tkt_pkg::NUMBER_W-1:0] key_number = '0;
  logic [tkt_pkg::VALUE_W-1:0] key_value = '0;
  logic result_valid;
  logic [tkt_pkg::CODE_W-1:0] result_code;
  logic [tkt_pkg::STATUS_W-1:0] found_status;
  logic [tkt_pkg::NUMBER_W-1:0] found_number;
  logic [tkt_pkg::VALUE_W-1:0] found_value;

  two_key_table_upsert_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .mode(mode),
    .client_id(client_id),
    .server_id(server_id),
    .key_status(key_status),
    .key_number(key_number),
    .key_value(key_value),
    .result_valid(result_valid),
    .result_code(result_code),
    .found_status(found_status),
    .found_number(found_number),
    .found_value(found_value)
  );

  always #1 clk = ~clk;

  // The predictor's own copy of the table and of the entry count.
  logic [tkt_pkg::ID_W-1:0]     rec_client [DEPTH] = '{default: '0};
  logic [tkt_pkg::ID_W-1:0]     rec_server [DEPTH] = '{default: '0};
  logic [tkt_pkg::STATUS_W-1:0] rec_status [DEPTH] = '{default: '0};
  logic [tkt_pkg::NUMBER_W-1:0] rec_number [DEPTH] = '{default: '0};
  logic [tkt_pkg::VALUE_W-1:0]  rec_value  [DEPTH] = '{default: '0};
  logic [tkt_pkg::COUNT_W-1:0]  span_cfg = tkt_pkg::COUNT_RESET;

  outcome_t pending_outcomes [$];
  row_t     steps [$];
  logic [tkt_pkg::ID_W-1:0] pool_client [POOL_SIZE];
  logic [tkt_pkg::ID_W-1:0] pool_server [POOL_SIZE];

  int accepted_total = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int code_seen [4] = '{default: 0};
  int reads_seen = 0;

  // Handed from the driver to the monitor for the request being presented.
  bit       use_typed = 1'b0;
  outcome_t typed_outcome = NO_CHECK;

  // Works out the answer to one request and applies a write to the table.
  // The search covers the first span_cfg entries, capped at the table depth.
  // It remembers the first entry whose two identifiers both match and the
  // first entry whose five fields are all zero.
  function automatic outcome_t upsert_or_lookup(request_t r);
    int span;
    int hit_at;
    int free_at;
    int dst;
    outcome_t o;
    span = int'(span_cfg);
    if (span > DEPTH) span = DEPTH;
    hit_at = -1;
    free_at = -1;
    for (int k = 0; k < span; k++) begin
      if (hit_at < 0 && rec_client[k] == r.client && rec_server[k] == r.server) hit_at = k;
      if (free_at < 0 && rec_client[k] == '0 && rec_server[k] == '0 &&
          rec_status[k] == '0 && rec_number[k] == '0 && rec_value[k] == '0) free_at = k;
    end
    o = NO_CHECK;
    if (r.rd == MODE_READ) begin
      if (hit_at >= 0) begin
        o.code   = tkt_pkg::RC_UPDATED;
        o.status = rec_status[hit_at];
        o.number = rec_number[hit_at];
        o.value  = rec_value[hit_at];
      end else begin
        o.code = tkt_pkg::RC_NOT_FOUND;
      end
    end else begin
      // An update wins over an insert; with neither the table is left alone.
      if (hit_at >= 0) begin
        o.code = tkt_pkg::RC_UPDATED;
        dst = hit_at;
      end else if (free_at >= 0) begin
        o.code = tkt_pkg::RC_INSERTED;
        dst = free_at;
      end else begin
        o.code = tkt_pkg::RC_FULL;
        dst = -1;
      end
      if (dst >= 0) begin
        rec_client[dst] = r.client;
        rec_server[dst] = r.server;
        rec_status[dst] = r.status;
        rec_number[dst] = r.number;
        rec_value[dst]  = r.value;
      end
    end
    return o;
  endfunction

  function automatic void report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    mismatches++;
  endfunction

  function automatic void add_request(request_t r, bit typed, outcome_t want);
    row_t row;
    row.kind  = ROW_REQUEST;
    row.span  = '0;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    steps.push_back(row);
  endfunction

  function automatic void add_span(logic [tkt_pkg::COUNT_W-1:0] v);
    row_t row;
    row.kind  = ROW_SPAN;
    row.span  = v;
    row.req   = '0;
    row.typed = 1'b0;
    row.want  = NO_CHECK;
    steps.push_back(row);
  endfunction

  // The monitor samples everything at the rising edge, where all inputs were
  // set up half a period earlier. A result is checked against the oldest
  // expectation; an accepted request is run through the predictor and its
  // answer is queued. A configuration write updates the predicted count.
  always @(posedge clk) begin : watch
    request_t req;
    outcome_t want;
    if (!rst) begin
      if (result_valid === 1'b1) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with no request waiting, code %0d", $time, result_code);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          if (result_code !== want.code)
            report_mismatch("result_code", 64'(want.code), 64'(result_code));
          if (found_status !== want.status)
            report_mismatch("found_status", 64'(want.status), 64'(found_status));
          if (found_number !== want.number)
            report_mismatch("found_number", 64'(want.number), 64'(found_number));
          if (found_value !== want.value)
            report_mismatch("found_value", want.value, found_value);
        end
      end
      if (cfg_write) span_cfg = cfg_data;
      if (start && busy === 1'b0) begin
        req = '{mode, client_id, server_id, key_status, key_number, key_value};
        want = upsert_or_lookup(req);
        code_seen[want.code]++;
        if (req.rd == MODE_READ) reads_seen++;
        if (use_typed) want = typed_outcome;
        pending_outcomes.push_back(want);
        accepted_total++;
      end
    end
  end

  // Hard stop in case the block hangs or never raises a result.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Presents one request at the falling edge and holds it until the monitor
  // has seen it accepted. With idle_pct set, the sender sometimes drops start
  // for a gap of up to three walks of the table, so that the next request
  // lands on any cycle of the block's work, including the result cycle.
  task automatic issue(input request_t r, input bit typed, input outcome_t want);
    int seen;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3 * DEPTH)) @(negedge clk);
    end
    seen = accepted_total;
    mode = r.rd;
    client_id = r.client;
    server_id = r.server;
    key_status = r.status;
    key_number = r.number;
    key_value = r.value;
    use_typed = typed;
    typed_outcome = want;
    start = 1'b1;
    do @(negedge clk); while (accepted_total == seen);
  endtask

  // Stops sending and waits until every answer is back and the block is idle.
  task automatic wait_drained();
    start = 1'b0;
    while (pending_outcomes.size() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_span(input logic [tkt_pkg::COUNT_W-1:0] v);
    cfg_data = v;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin : stimulus
    localparam logic [tkt_pkg::ID_W-1:0] CA = 64'h0123_4567_89ab_cdef;
    localparam logic [tkt_pkg::ID_W-1:0] SA = 64'hfedc_ba98_7654_3210;
    localparam logic [tkt_pkg::ID_W-1:0] SC = 64'h5555_5555_5555_5555;
    localparam logic [tkt_pkg::ID_W-1:0] CD = 64'h8000_0000_0000_0001;
    localparam logic [tkt_pkg::ID_W-1:0] SD = 64'h0000_0000_0000_0080;
    localparam logic [tkt_pkg::ID_W-1:0] ONES = '1;
    phase_t plan [9];
    request_t r;
    int k;
    int pick;

    // Identifier pool: some neighbors share a client or a server identifier,
    // so a match on one identifier alone must not count as a hit.
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_client[i] = (i % 3 == 1) ? pool_client[i - 1] : {$urandom, $urandom};
      pool_server[i] = (i % 5 == 2) ? pool_server[i - 1] : {$urandom, $urandom};
    end

    // Directed part. The table starts empty with all 64 entries searched.
    add_request('{MODE_READ, CA, SA, 8'h00, 32'h0, 64'h0}, 1'b1,
                '{tkt_pkg::RC_NOT_FOUND, 8'h00, 32'h0, 64'h0});
    add_request('{MODE_WRITE, CA, SA, 8'hff, 32'hffff_ffff, ONES}, 1'b1,
                '{tkt_pkg::RC_INSERTED, 8'h00, 32'h0, 64'h0});
    add_request('{MODE_READ, CA, SA, 8'h00, 32'h0, 64'h0}, 1'b1,
                '{tkt_pkg::RC_UPDATED, 8'hff, 32'hffff_ffff, ONES});
    add_request('{MODE_WRITE, CA, SA, 8'h5a, 32'h1234_5678, 64'ha5a5_a5a5_0f0f_0f0f}, 1'b1,
                '{tkt_pkg::RC_UPDATED, 8'h00, 32'h0, 64'h0});
    add_request('{MODE_READ, CA, SA, 8'h00, 32'h0, 64'h0}, 1'b0, NO_CHECK);
    add_request('{MODE_WRITE, ONES, ONES, 8'h00, 32'h0, 64'h1}, 1'b1,
                '{tkt_pkg::RC_INSERTED, 8'h00, 32'h0, 64'h0});
    // Identifiers of zero match the first empty entry like any record.
    add_request('{MODE_READ, 64'h0, 64'h0, 8'h00, 32'h0, 64'h0}, 1'b1,
                '{tkt_pkg::RC_UPDATED, 8'h00, 32'h0, 64'h0});
    add_request('{MODE_WRITE, 64'h0, 64'h0, 8'h00, 32'h0, 64'h0}, 1'b1,
                '{tkt_pkg::RC_UPDATED, 8'h00, 32'h0, 64'h0});
    add_request('{MODE_WRITE, 64'h0, 64'h0, 8'h07, 32'h9, 64'hb}, 1'b0, NO_CHECK);
    add_request('{MODE_READ, 64'h0, 64'h0, 8'h00, 32'h0, 64'h0}, 1'b0, NO_CHECK);
    add_request('{MODE_WRITE, CA, SC, 8'h3c, 32'h8000_0000, 64'h8000_0000_0000_0000},
                1'b0, NO_CHECK);
    // With no entry searched, writes report full and reads miss.
    add_span(7'd0);
    add_request('{MODE_WRITE, CD, SD, 8'h11, 32'h22, 64'h33}, 1'b1,
                '{tkt_pkg::RC_FULL, 8'h00, 32'h0, 64'h0});
    add_request('{MODE_READ, CA, SA, 8'h00, 32'h0, 64'h0}, 1'b1,
                '{tkt_pkg::RC_NOT_FOUND, 8'h00, 32'h0, 64'h0});
    // One entry searched and occupied: a new pair finds the table full.
    add_span(7'd1);
    add_request('{MODE_READ, CA, SA, 8'h00, 32'h0, 64'h0}, 1'b0, NO_CHECK);
    add_request('{MODE_WRITE, CD, SD, 8'h11, 32'h22, 64'h33}, 1'b1,
                '{tkt_pkg::RC_FULL, 8'h00, 32'h0, 64'h0});
    add_request('{MODE_READ, ONES, ONES, 8'h00, 32'h0, 64'h0}, 1'b1,
                '{tkt_pkg::RC_NOT_FOUND, 8'h00, 32'h0, 64'h0});
    // Counts above the depth search the whole table.
    add_span(7'd127);
    add_request('{MODE_READ, ONES, ONES, 8'h00, 32'h0, 64'h0}, 1'b0, NO_CHECK);
    add_request('{MODE_WRITE, CD, SD, 8'h11, 32'h22, 64'h33}, 1'b0, NO_CHECK);
    add_span(7'd65);
    add_request('{MODE_READ, CD, SD, 8'h00, 32'h0, 64'h0}, 1'b0, NO_CHECK);
    add_request('{MODE_WRITE, ONES, ONES, 8'h00, 32'h0, 64'h0}, 1'b0, NO_CHECK);
    add_span(7'd64);
    add_request('{MODE_READ, CA, SC, 8'h00, 32'h0, 64'h0}, 1'b0, NO_CHECK);

    // Random phases. The third one offers many fresh pairs with mostly
    // writes, so the table fills up and later phases see full answers.
    plan[0] = '{4, 0, 50, 6, 60};
    plan[1] = '{64, 83, 40, 10, 50};
    plan[2] = '{64, 0, 110, 100, 85};
    plan[3] = '{127, 29, 50, 40, 50};
    plan[4] = '{2, 83, 30, 4, 60};
    plan[5] = '{0, 0, 15, 8, 50};
    plan[6] = '{1, 29, 30, 3, 60};
    plan[7] = '{9, 0, 60, 20, 55};
    plan[8] = '{65, 29, 50, 128, 50};

    repeat (4) @(negedge clk);
    rst = 1'b0;

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_SPAN) begin
        wait_drained();
        write_span(steps[i].span);
      end else begin
        issue(steps[i].req, steps[i].typed, steps[i].want);
      end
    end

    // Each phase starts from an idle block, which is also where the sender
    // pauses until every answer has come back.
    foreach (plan[p]) begin
      wait_drained();
      write_span(plan[p].span[tkt_pkg::COUNT_W-1:0]);
      idle_pct = plan[p].idle;
      for (int i = 0; i < plan[p].items; i++) begin
        k = $urandom_range(plan[p].pool - 1);
        pick = $urandom_range(99);
        r.rd = ($urandom_range(99) < plan[p].wr) ? MODE_WRITE : MODE_READ;
        if (pick < 85) begin
          r.client = pool_client[k];
          r.server = pool_server[k];
        end else if (pick < 92) begin
          r.client = '0;
          r.server = '0;
        end else begin
          r.client = {$urandom, $urandom};
          r.server = {$urandom, $urandom};
        end
        r.status = 8'($urandom);
        r.number = $urandom;
        r.value = {$urandom, $urandom};
        // An all-zero payload under zero identifiers turns an entry empty again.
        if ($urandom_range(15) == 0) begin
          r.status = '0;
          r.number = '0;
          r.value = '0;
        end
        issue(r, 1'b0, NO_CHECK);
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (pending_outcomes.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, pending_outcomes.size());
      mismatches++;
    end

    $display("Ran %0d requests (%0d reads) with entry counts from 0 to 127,",
             accepted_total, reads_seen);
    $display("giving %0d updates or hits, %0d inserts, %0d full and %0d misses.",
             code_seen[tkt_pkg::RC_UPDATED], code_seen[tkt_pkg::RC_INSERTED],
             code_seen[tkt_pkg::RC_FULL], code_seen[tkt_pkg::RC_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
